### rtl/lfpd_pkg.sv
`default_nettype none

package lfpd_pkg;

    // Field widths
    localparam int LEVEL_W  = 16;
    localparam int SCALE_W  = 16;
    localparam int DIV_W    = 16;
    localparam int GAIN_W   = 10;
    localparam int LIMIT_W  = 10;
    localparam int ACTION_W = 2;
    localparam int SPEED_W  = 11;

    // Internal arithmetic widths
    localparam int ERR_W  = 17;             // full_scale - level
    localparam int DIFF_W = 18;             // error - previous error
    localparam int MAG_W  = 17;             // magnitude of a multiplier operand
    localparam int PROD_W = GAIN_W + MAG_W; // 27
    localparam int QUO_W  = 28;             // dividend padded to 2 bits per step
    localparam int ACC_W  = 30;             // limit plus two quotients, signed
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int STEP_CNT_W = 4;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    localparam logic [2:0] REG_FULL_SCALE = 3'd0;
    localparam logic [2:0] REG_DIVISOR    = 3'd1;
    localparam logic [2:0] REG_LIMIT      = 3'd2;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd3;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd4;

    // Reset values of the configuration registers
    localparam logic [SCALE_W-1:0] RST_FULL_SCALE = 16'd23999;
    localparam logic [DIV_W-1:0]   RST_DIVISOR    = 16'd18999;
    localparam logic [LIMIT_W-1:0] RST_LIMIT      = 10'd255;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 10'd340;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 10'd68;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_DRIVE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_HALT  = 2'd2;

    // Leave counter
    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] CNT_SAT       = 3'd4;
    localparam logic [CNT_W-1:0] CNT_STOP_AT   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_HALT_AT   = 3'd3;

    typedef logic signed [ACC_W-1:0] acc_t;

endpackage

`default_nettype wire

### rtl/line_follower_pd_steering.sv
// PD steering for a line-following robot with differential drive.
// Input stream (s_*): one sensor sample per control tick, two centre
// reflectance levels and four digital line bits. Output stream (m_*): one
// result per sample, the action (drive, stop-and-wait, halt) and the two
// clamped wheel speeds. The cfg_* port writes the five tuning registers; the user
// must write them only while the block is idle, and the block does not enforce it.
// A sample with all four line bits at zero may end at once in a stop or halt
// result. A drive sample runs four multiply and divide jobs (P and D for each
// wheel) through one shared 10x17 multiplier and one restoring divider that
// retires two quotient bits a cycle. s_tready is high only while no sample is
// in work, so a new sample is not taken before the last one is through.
// The result sits in an output register; a stalled receiver holds it while
// the next sample is accepted and computed, and the finished result then
// waits until the register frees up.
// Reset restores the register defaults, clears the saved errors and the leave
// count, sets the all-zero mode and empties the output register.
`default_nettype none

module line_follower_pd_steering (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: left_level[15:0], right_level[31:16], bit_far_left[32],
    // bit_near_left[33], bit_near_right[34], bit_far_right[35], zero[39:36]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [lfpd_pkg::IN_DATA_W-1:0] s_tdata,
    // m_tdata: action[1:0], left_speed[12:2], right_speed[23:13]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [lfpd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int ERR_W   = lfpd_pkg::ERR_W;
    localparam int DIFF_W  = lfpd_pkg::DIFF_W;
    localparam int MAG_W   = lfpd_pkg::MAG_W;
    localparam int PROD_W  = lfpd_pkg::PROD_W;
    localparam int QUO_W   = lfpd_pkg::QUO_W;
    localparam int ACC_W   = lfpd_pkg::ACC_W;
    localparam int DIV_W   = lfpd_pkg::DIV_W;
    localparam int SPEED_W = lfpd_pkg::SPEED_W;
    localparam int LIMIT_W = lfpd_pkg::LIMIT_W;
    localparam int CNT_W   = lfpd_pkg::CNT_W;
    localparam int SC_W    = lfpd_pkg::STEP_CNT_W;
    localparam logic [SC_W-1:0] LAST_STEP = SC_W'(lfpd_pkg::DIV_STEPS - 1);

    // Configuration
    logic [lfpd_pkg::SCALE_W-1:0] full_scale_reg;
    logic [DIV_W-1:0]             divisor_reg;
    logic [LIMIT_W-1:0]           limit_reg;
    logic [lfpd_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic [lfpd_pkg::GAIN_W-1:0]  deriv_gain_reg;

    // Control and state
    logic [2:0]        state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        job_reg, job_next;
    logic [SC_W-1:0]   step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath
    logic signed [ERR_W-1:0]   prev_l_reg, prev_l_next;
    logic signed [ERR_W-1:0]   prev_r_reg, prev_r_next;
    logic signed [ERR_W-1:0]   err_l_reg, err_l_next;
    logic signed [ERR_W-1:0]   err_r_reg, err_r_next;
    logic [DIV_W-1:0]          dvs_reg, dvs_next;
    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic                      neg_reg, neg_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [lfpd_pkg::ACTION_W-1:0] act_reg, act_next;
    logic signed [SPEED_W-1:0] sl_reg, sl_next;
    logic signed [SPEED_W-1:0] sr_reg, sr_next;
    logic [lfpd_pkg::ACTION_W-1:0] out_act_reg, out_act_next;
    logic signed [SPEED_W-1:0] out_sl_reg, out_sl_next;
    logic signed [SPEED_W-1:0] out_sr_reg, out_sr_next;

    // Input fields
    logic [lfpd_pkg::LEVEL_W-1:0] in_left;
    logic [lfpd_pkg::LEVEL_W-1:0] in_right;
    logic                         in_zeros;
    logic                         s_accept;

    // Multiply phase
    logic signed [ERR_W-1:0]  mul_err;
    logic signed [ERR_W-1:0]  mul_prev;
    logic signed [DIFF_W-1:0] mul_diff;
    logic signed [DIFF_W-1:0] mul_op;
    logic [MAG_W-1:0]         mul_mag;
    logic [lfpd_pkg::GAIN_W-1:0] mul_gain;
    logic [PROD_W-1:0]        mul_prod;

    // Divide phase
    logic [DIV_W:0]   t1, t2;
    logic             qb1, qb2;
    logic [DIV_W-1:0] r1, r2;

    // Accumulate phase
    logic signed [ACC_W-1:0] q_signed;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] lim_s;
    logic signed [SPEED_W-1:0] clamped;

    assign in_left  = s_tdata[15:0];
    assign in_right = s_tdata[31:16];
    assign in_zeros = ~(s_tdata[32] | s_tdata[33] | s_tdata[34] | s_tdata[35]);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sr_reg, out_sl_reg, out_act_reg};

    // Multiplier operand: job bit 1 picks the wheel, bit 0 picks P or D
    always_comb
    begin
        mul_err  = job_reg[1] ? err_r_reg  : err_l_reg;
        mul_prev = job_reg[1] ? prev_r_reg : prev_l_reg;
        mul_diff = DIFF_W'(mul_err) - DIFF_W'(mul_prev);
        mul_op   = job_reg[0] ? mul_diff : DIFF_W'(mul_err);
        mul_mag  = mul_op[DIFF_W-1] ? MAG_W'(-mul_op) : MAG_W'(mul_op);
        mul_gain = job_reg[0] ? deriv_gain_reg : prop_gain_reg;
        mul_prod = PROD_W'(mul_gain) * PROD_W'(mul_mag);
    end

    // Two restoring divide steps per cycle
    always_comb
    begin
        t1  = {rem_reg, quo_reg[QUO_W-1]};
        qb1 = (t1 >= {1'b0, dvs_reg});
        r1  = qb1 ? DIV_W'(t1 - {1'b0, dvs_reg}) : t1[DIV_W-1:0];
        t2  = {r1, quo_reg[QUO_W-2]};
        qb2 = (t2 >= {1'b0, dvs_reg});
        r2  = qb2 ? DIV_W'(t2 - {1'b0, dvs_reg}) : t2[DIV_W-1:0];
    end

    // Signed quotient folded into the wheel accumulator, then clamped
    always_comb
    begin
        q_signed = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        lim_s    = $signed({{(ACC_W-LIMIT_W){1'b0}}, limit_reg});
        acc_sum  = job_reg[0] ? (acc_reg + q_signed) : (lim_s - q_signed);
        if (acc_sum > lim_s)
        begin
            clamped = $signed({1'b0, limit_reg});
        end
        else if (acc_sum < -lim_s)
        begin
            clamped = -$signed({1'b0, limit_reg});
        end
        else
        begin
            clamped = acc_sum[SPEED_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        err_l_next     = err_l_reg;
        err_r_next     = err_r_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        act_next       = act_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        out_act_next   = out_act_reg;
        out_sl_next    = out_sl_reg;
        out_sr_next    = out_sr_reg;

        // Drop the result once the receiver takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_zeros != mode_reg)
                    begin
                        if (mode_reg && count_reg < lfpd_pkg::CNT_SAT)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        mode_next = in_zeros;
                    end
                    err_l_next = $signed({1'b0, full_scale_reg}) - $signed({1'b0, in_left});
                    err_r_next = $signed({1'b0, full_scale_reg}) - $signed({1'b0, in_right});
                    dvs_next   = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
                    job_next   = 2'd0;
                    sl_next    = '0;
                    sr_next    = '0;
                    if (mode_next && count_next == lfpd_pkg::CNT_STOP_AT)
                    begin
                        act_next   = lfpd_pkg::ACT_STOP;
                        state_next = ST_DONE;
                    end
                    else if (mode_next && count_next == lfpd_pkg::CNT_HALT_AT)
                    begin
                        act_next   = lfpd_pkg::ACT_HALT;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        act_next   = lfpd_pkg::ACT_DRIVE;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                quo_next   = {{(QUO_W-PROD_W){1'b0}}, mul_prod};
                rem_next   = '0;
                neg_next   = mul_op[DIFF_W-1];
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = r2;
                quo_next  = {quo_reg[QUO_W-3:0], qb1, qb2};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next = acc_sum;
                if (job_reg[0])
                begin
                    if (job_reg[1])
                    begin
                        sl_next = clamped;
                    end
                    else
                    begin
                        sr_next = clamped;
                    end
                end
                if (job_reg == 2'd3)
                begin
                    prev_l_next = err_l_reg;
                    prev_r_next = err_r_reg;
                    state_next  = ST_DONE;
                end
                else
                begin
                    job_next   = job_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register frees up
                if (!out_valid_reg || m_tready)
                begin
                    out_act_next   = act_reg;
                    out_sl_next    = sl_reg;
                    out_sr_next    = sr_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= lfpd_pkg::RST_FULL_SCALE;
            divisor_reg    <= lfpd_pkg::RST_DIVISOR;
            limit_reg      <= lfpd_pkg::RST_LIMIT;
            prop_gain_reg  <= lfpd_pkg::RST_PROP_GAIN;
            deriv_gain_reg <= lfpd_pkg::RST_DERIV_GAIN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lfpd_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_wdata;
                lfpd_pkg::REG_DIVISOR:    divisor_reg    <= cfg_wdata;
                lfpd_pkg::REG_LIMIT:      limit_reg      <= cfg_wdata[LIMIT_W-1:0];
                lfpd_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b1;
            count_reg     <= '0;
            job_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            job_reg       <= job_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_l_reg   <= err_l_next;
        err_r_reg   <= err_r_next;
        dvs_reg     <= dvs_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
        act_reg     <= act_next;
        sl_reg      <= sl_next;
        sr_reg      <= sr_next;
        out_act_reg <= out_act_next;
        out_sl_reg  <= out_sl_next;
        out_sr_reg  <= out_sr_next;
    end

endmodule

`default_nettype wire
